>>> rtl/aelsic_pkg.sv
// Package with payload types and constants for the extra load/store issue check.
package aelsic_pkg;

    localparam logic [3:0] PC_REG = 4'd15;
    localparam logic [3:0] LR_REG = 4'd14;
    localparam logic [9:0] KB_MASK = 10'h3FF;
    localparam logic [31:0] DUAL_STEP = 32'd4;

    localparam logic [1:0] OP2_NONE = 2'd0;
    localparam logic [1:0] OP2_HALF = 2'd1;
    localparam logic [1:0] OP2_SBYTE_DUAL = 2'd2;
    localparam logic [1:0] OP2_SHALF_DUAL = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_DUAL = 2'd2;

    localparam logic [2:0] REG_UNPRIV = 3'd0;
    localparam logic [2:0] REG_DUAL = 3'd1;
    localparam logic [2:0] REG_V6 = 3'd2;
    localparam logic [2:0] REG_RESTORED = 3'd3;
    localparam logic [2:0] REG_ALIGN = 3'd4;
    localparam logic [2:0] REG_DMASK = 3'd5;

    typedef struct packed {
        logic [2:0]  transfer_kind;
        logic        pre_index;
        logic        write_back_bit;
        logic        add_offset;
        logic        immediate_form;
        logic        unprivileged;
        logic [3:0]  rt_index;
        logic [3:0]  rn_index;
        logic [3:0]  rm_index;
        logic [1:0]  rm_shift;
        logic [31:0] base_value;
        logic [31:0] offset_operand;
    } t_issue_in;

    typedef struct packed {
        logic        undefined;
        logic [31:0] access_address;
        logic [31:0] second_address;
        logic [1:0]  access_size;
        logic        store_op;
        logic        sign_extend;
        logic        alignment_fault;
        logic        crosses_boundary;
        logic        writeback_enable;
        logic [31:0] writeback_value;
        logic        writeback_on_abort;
    } t_issue_out;

endpackage

>>> rtl/arm_extra_load_store_issue_check.sv
// Top level: undefined check and address generation for extra load/store transfers.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data (t_issue_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_issue_out)
//  config  | input     | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// Each transfer passes through the input register and then the result register, and one
// transfer is taken every cycle while the input side is not stalled.
// The input side stalls only when both registers are full and the output is stalled.
// Reset clears the valid bits and loads the configuration reset values.
module arm_extra_load_store_issue_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  aelsic_pkg::t_issue_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aelsic_pkg::t_issue_out o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import aelsic_pkg::*;

    logic       r_unpriv;
    logic       r_dual;
    logic       r_v6;
    logic       r_restored;
    logic       r_align;
    logic [2:0] r_dmask;

    logic       r_s1_valid;
    t_issue_in  r_s1;
    logic       r_out_valid;
    t_issue_out r_out;
    t_issue_out n_out;

    logic       w_adv;
    logic [2:0] w_reg;

    assign pready = 1'b1;
    assign w_reg = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unpriv   <= 1'b1;
            r_dual     <= 1'b1;
            r_v6       <= 1'b1;
            r_restored <= 1'b0;
            r_align    <= 1'b0;
            r_dmask    <= 3'd7;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_UNPRIV:   r_unpriv <= pwdata[0];
                REG_DUAL:     r_dual <= pwdata[0];
                REG_V6:       r_v6 <= pwdata[0];
                REG_RESTORED: r_restored <= pwdata[0];
                REG_ALIGN:    r_align <= pwdata[0];
                REG_DMASK:    r_dmask <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_UNPRIV:   prdata = {31'd0, r_unpriv};
            REG_DUAL:     prdata = {31'd0, r_dual};
            REG_V6:       prdata = {31'd0, r_v6};
            REG_RESTORED: prdata = {31'd0, r_restored};
            REG_ALIGN:    prdata = {31'd0, r_align};
            REG_DMASK:    prdata = {29'd0, r_dmask};
            default:      prdata = 32'd0;
        endcase
    end

    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in_data;
        end
    end

    always_comb begin
        logic [1:0]  op2;
        logic        load;
        logic        is_dual;
        logic        store;
        logic        is_half;
        logic        wback;
        logic        und;
        logic [4:0]  rt_next;
        logic [31:0] shifted;
        logic [31:0] offaddr;
        logic [31:0] addr;

        op2      = r_s1.transfer_kind[2:1];
        load     = r_s1.transfer_kind[0];
        is_dual  = !load && (op2 == OP2_SBYTE_DUAL || op2 == OP2_SHALF_DUAL);
        store    = !load && (op2 == OP2_HALF || op2 == OP2_SHALF_DUAL);
        is_half  = (op2 == OP2_HALF) || (op2 == OP2_SHALF_DUAL && load);
        wback    = !r_s1.pre_index || r_s1.write_back_bit;
        rt_next  = {1'b0, r_s1.rt_index} + 5'd1;

        und = 1'b0;
        if (op2 == OP2_NONE) und = 1'b1;
        if (r_s1.unprivileged && !r_unpriv) und = 1'b1;
        if (is_dual && !r_dual) und = 1'b1;
        if (is_dual) begin
            if (r_s1.rt_index[0] || r_s1.rt_index == LR_REG) und = 1'b1;
            if (!r_s1.pre_index && r_s1.write_back_bit) und = 1'b1;
            if (wback && (r_s1.rn_index == PC_REG || r_s1.rn_index == r_s1.rt_index
                    || {1'b0, r_s1.rn_index} == rt_next)) begin
                und = 1'b1;
            end
            if (!r_s1.immediate_form) begin
                if (r_s1.rm_index == PC_REG) und = 1'b1;
                if (!store && (r_s1.rm_index == r_s1.rt_index
                        || {1'b0, r_s1.rm_index} == rt_next)) begin
                    und = 1'b1;
                end
            end
        end else begin
            if (r_s1.rt_index == PC_REG) und = 1'b1;
            if (wback && (r_s1.rn_index == PC_REG || r_s1.rn_index == r_s1.rt_index)) begin
                und = 1'b1;
            end
            if (!r_s1.immediate_form && r_s1.rm_index == PC_REG) und = 1'b1;
        end
        if (!r_s1.immediate_form && wback && !r_v6 && r_s1.rm_index == r_s1.rn_index) begin
            und = 1'b1;
        end

        shifted = r_s1.offset_operand << r_s1.rm_shift;
        if (r_s1.immediate_form) begin
            offaddr = r_s1.base_value + r_s1.offset_operand;
        end else if (r_s1.add_offset) begin
            offaddr = r_s1.base_value + shifted;
        end else begin
            offaddr = r_s1.base_value - shifted;
        end

        priority if (!r_s1.pre_index) begin
            addr = r_s1.base_value;
        end else if (r_s1.immediate_form && r_s1.rn_index == PC_REG) begin
            addr = {r_s1.base_value[31:2], 2'b00} + r_s1.offset_operand;
        end else begin
            addr = offaddr;
        end

        n_out = '0;
        if (und) begin
            n_out.undefined = 1'b1;
        end else begin
            n_out.access_address = addr;
            n_out.second_address = is_dual ? addr + DUAL_STEP : 32'd0;
            n_out.access_size = is_dual ? SIZE_DUAL : (is_half ? SIZE_HALF : SIZE_BYTE);
            n_out.store_op = store;
            n_out.sign_extend = load && op2[1];
            if (is_half) begin
                n_out.alignment_fault = r_align && addr[0];
                n_out.crosses_boundary = !r_align && (addr[9:0] == KB_MASK);
            end else if (is_dual) begin
                n_out.alignment_fault = (addr[2:0] & r_dmask) != 3'd0;
            end
            n_out.writeback_enable = wback;
            n_out.writeback_value = wback ? offaddr : 32'd0;
            n_out.writeback_on_abort = wback && !r_restored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_adv |=> r_out_valid)
        else $error("input register content did not reach the result register");

    a_undef_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.undefined |-> !r_out.writeback_enable
            && r_out.access_address == 32'd0 && r_out.second_address == 32'd0)
        else $error("undefined transfer carries address or writeback");

    a_second_only_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.access_size != SIZE_DUAL |-> r_out.second_address == 32'd0)
        else $error("second address set for a single transfer");

    a_cross_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.crosses_boundary |-> r_out.access_size == SIZE_HALF
            && !r_out.alignment_fault)
        else $error("boundary crossing reported for a non-halfword or faulting transfer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && r_s1_valid)
        else $error("input stalled while the pipeline has room");
`endif

endmodule

>>> bench/arm_extra_load_store_issue_check_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the extra load/store issue check with a predictor and APB setup.
module arm_extra_load_store_issue_check_tb;
    import aelsic_pkg::*;

    localparam logic [2:0] KIND_NONE_ST = {OP2_NONE, 1'b0};
    localparam logic [2:0] KIND_NONE_LD = {OP2_NONE, 1'b1};
    localparam logic [2:0] KIND_STRH = {OP2_HALF, 1'b0};
    localparam logic [2:0] KIND_LDRH = {OP2_HALF, 1'b1};
    localparam logic [2:0] KIND_LDRD = {OP2_SBYTE_DUAL, 1'b0};
    localparam logic [2:0] KIND_LDRSB = {OP2_SBYTE_DUAL, 1'b1};
    localparam logic [2:0] KIND_STRD = {OP2_SHALF_DUAL, 1'b0};
    localparam logic [2:0] KIND_LDRSH = {OP2_SHALF_DUAL, 1'b1};
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 100;

    typedef struct {
        bit       unpriv;
        bit       dual;
        bit       v6;
        bit       restored;
        bit       align;
        bit [2:0] dmask;
    } t_issue_cfg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_issue_in   in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_issue_out  o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_issue_cfg cfg = '{unpriv: 1'b1, dual: 1'b1, v6: 1'b1, restored: 1'b0,
                        align: 1'b0, dmask: 3'd7};
    t_issue_out pending_issue_results[$];
    int fail_count = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    arm_extra_load_store_issue_check i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data(o_out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_issue_out predict_issue_check(t_issue_in x);
        t_issue_out r;
        logic [1:0] op2;
        logic load;
        logic dual;
        logic store;
        logic half;
        logic wback;
        logic und;
        logic [4:0] rt_next;
        logic [31:0] shifted;
        logic [31:0] off_addr;
        logic [31:0] addr;
        op2 = x.transfer_kind[2:1];
        load = x.transfer_kind[0];
        dual = !load && (op2 == OP2_SBYTE_DUAL || op2 == OP2_SHALF_DUAL);
        store = !load && (op2 == OP2_HALF || op2 == OP2_SHALF_DUAL);
        half = op2 == OP2_HALF || (op2 == OP2_SHALF_DUAL && load);
        wback = !x.pre_index || x.write_back_bit;
        rt_next = {1'b0, x.rt_index} + 5'd1;
        r = '0;
        und = op2 == OP2_NONE || (x.unprivileged && !cfg.unpriv) || (dual && !cfg.dual);
        if (dual) begin
            if (x.rt_index[0] || x.rt_index == LR_REG)
                und = 1'b1;
            if (!x.pre_index && x.write_back_bit)
                und = 1'b1;
            if (wback && (x.rn_index == PC_REG || x.rn_index == x.rt_index
                          || {1'b0, x.rn_index} == rt_next))
                und = 1'b1;
            if (!x.immediate_form && (x.rm_index == PC_REG || (!store
                    && (x.rm_index == x.rt_index || {1'b0, x.rm_index} == rt_next))))
                und = 1'b1;
        end else begin
            if (x.rt_index == PC_REG)
                und = 1'b1;
            if (wback && (x.rn_index == PC_REG || x.rn_index == x.rt_index))
                und = 1'b1;
            if (!x.immediate_form && x.rm_index == PC_REG)
                und = 1'b1;
        end
        if (!x.immediate_form && wback && !cfg.v6 && x.rm_index == x.rn_index)
            und = 1'b1;
        if (und) begin
            r.undefined = 1'b1;
            return r;
        end
        shifted = x.offset_operand << x.rm_shift;
        if (x.immediate_form)
            off_addr = x.base_value + x.offset_operand;
        else if (x.add_offset)
            off_addr = x.base_value + shifted;
        else
            off_addr = x.base_value - shifted;
        if (!x.pre_index)
            addr = x.base_value;
        else if (x.immediate_form && x.rn_index == PC_REG)
            addr = (x.base_value & 32'hFFFF_FFFC) + x.offset_operand;
        else
            addr = off_addr;
        if (half) begin
            if (cfg.align)
                r.alignment_fault = addr[0];
            else
                r.crosses_boundary = addr[9:0] == KB_MASK;
        end else if (dual) begin
            r.alignment_fault = (addr[2:0] & cfg.dmask) != 3'd0;
        end
        r.access_address = addr;
        r.second_address = dual ? addr + DUAL_STEP : 32'd0;
        r.access_size = dual ? SIZE_DUAL : (half ? SIZE_HALF : SIZE_BYTE);
        r.store_op = store;
        r.sign_extend = load && (op2 == OP2_SBYTE_DUAL || op2 == OP2_SHALF_DUAL);
        r.writeback_enable = wback;
        r.writeback_value = wback ? off_addr : 32'd0;
        r.writeback_on_abort = wback && !cfg.restored;
        return r;
    endfunction

    function automatic t_issue_in make_issue(logic [2:0] kind, int p, int w, int u, int imm,
                                             int unpriv, int rt, int rn,
                                             int rm, int sh,
                                             logic [31:0] base, logic [31:0] ofs);
        t_issue_in x;
        x.transfer_kind = kind;
        x.pre_index = p[0];
        x.write_back_bit = w[0];
        x.add_offset = u[0];
        x.immediate_form = imm[0];
        x.unprivileged = unpriv[0];
        x.rt_index = rt[3:0];
        x.rn_index = rn[3:0];
        x.rm_index = rm[3:0];
        x.rm_shift = sh[1:0];
        x.base_value = base;
        x.offset_operand = ofs;
        return x;
    endfunction

    function automatic t_issue_in random_issue();
        t_issue_in x;
        t_issue_out probe;
        int tries;
        x = make_issue(3'($urandom_range(7, 0)), int'($urandom), int'($urandom),
                       int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom), int'($urandom), int'($urandom), $urandom, $urandom);
        if ($urandom_range(3, 0) != 0) begin
            if (cfg.dual)
                x.transfer_kind = 3'($urandom_range(7, 2));
            else
                case ($urandom_range(3, 0))
                    0: x.transfer_kind = KIND_STRH;
                    1: x.transfer_kind = KIND_LDRH;
                    2: x.transfer_kind = KIND_LDRSB;
                    default: x.transfer_kind = KIND_LDRSH;
                endcase
            if (!cfg.unpriv)
                x.unprivileged = 1'b0;
            if (!x.pre_index && (x.transfer_kind == KIND_LDRD || x.transfer_kind == KIND_STRD))
                x.write_back_bit = 1'b0;
            case ($urandom_range(3, 0))
                0: x.offset_operand = 32'($urandom_range(511, 0)) - 32'd256;
                1: begin
                    x.base_value[9:0] = 10'h3F8 + 10'($urandom_range(7, 0));
                    x.offset_operand = 32'($urandom_range(8, 0)) - 32'd4;
                end
                2: begin
                    x.base_value[2:0] = 3'd0;
                    x.offset_operand = 32'($urandom_range(64, 0)) * 32'd4 - 32'd128;
                end
                default: ;
            endcase
            for (tries = 0; tries < 32; tries++) begin
                probe = predict_issue_check(x);
                if (!probe.undefined)
                    break;
                x.rt_index = 4'($urandom);
                x.rn_index = 4'($urandom);
                x.rm_index = 4'($urandom);
                if (x.transfer_kind == KIND_LDRD || x.transfer_kind == KIND_STRD)
                    x.rt_index[0] = 1'b0;
            end
        end
        return x;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 75)
            return 0;
        if (r < 97)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 100)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task automatic send_transfer(input t_issue_in item);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_issue_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [2:0] reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (reg_idx)
            REG_UNPRIV: cfg.unpriv = value[0];
            REG_DUAL: cfg.dual = value[0];
            REG_V6: cfg.v6 = value[0];
            REG_RESTORED: cfg.restored = value[0];
            REG_ALIGN: cfg.align = value[0];
            REG_DMASK: cfg.dmask = value[2:0];
            default: ;
        endcase
    endtask

    task automatic test_directed_defaults();
        send_transfer(make_issue(KIND_LDRH, 1, 0, 1, 1, 0, 1, 2, 0, 0, 32'h3FD, 32'd2));
        send_transfer(make_issue(KIND_STRH, 0, 0, 1, 1, 1, 3, 4, 0, 0, 32'h1000, 32'hFFFF_FFFE));
        send_transfer(make_issue(KIND_LDRSB, 1, 1, 0, 0, 0, 5, 6, 7, 3, '1, '1));
        send_transfer(make_issue(KIND_LDRSH, 1, 0, 1, 0, 0, 0, 1, 2, 0, '0, '0));
        send_transfer(make_issue(KIND_LDRD, 1, 1, 1, 1, 0, 2, 5, 0, 0, 32'h100, 32'd8));
        send_transfer(make_issue(KIND_STRD, 1, 0, 1, 0, 0, 4, 8, 4, 1, 32'h200, 32'd4));
        send_transfer(make_issue(KIND_STRD, 0, 0, 0, 0, 0, 4, 8, 5, 2, 32'h208, 32'd2));
        send_transfer(make_issue(KIND_STRD, 1, 0, 1, 0, 0, 4, 8, 15, 0, 32'h200, 32'd4));
        send_transfer(make_issue(KIND_LDRD, 1, 0, 1, 0, 0, 4, 8, 5, 0, 32'h200, 32'd4));
        send_transfer(make_issue(KIND_LDRD, 1, 0, 1, 1, 0, 3, 8, 0, 0, 32'h200, 32'd0));
        send_transfer(make_issue(KIND_LDRD, 1, 0, 1, 1, 0, 14, 8, 0, 0, 32'h200, 32'd0));
        send_transfer(make_issue(KIND_STRD, 0, 1, 1, 1, 0, 2, 8, 0, 0, 32'h200, 32'd0));
        send_transfer(make_issue(KIND_LDRD, 1, 1, 1, 1, 0, 2, 3, 0, 0, 32'h200, 32'd0));
        send_transfer(make_issue(KIND_NONE_ST, 0, 0, 0, 0, 0, 0, 0, 0, 0, '0, '0));
        send_transfer(make_issue(KIND_NONE_LD, 1, 0, 1, 1, 0, 1, 2, 3, 0, 32'h40, 32'd4));
        send_transfer(make_issue(KIND_LDRH, 1, 0, 1, 1, 0, 15, 2, 0, 0, 32'h40, 32'd4));
        send_transfer(make_issue(KIND_LDRH, 0, 0, 1, 1, 0, 6, 6, 0, 0, 32'h40, 32'd4));
        send_transfer(make_issue(KIND_LDRH, 1, 0, 1, 1, 0, 1, 15, 0, 0, 32'h8002, 32'h10));
        send_transfer(make_issue(KIND_LDRSB, 1, 0, 1, 1, 0, 1, 15, 0, 0, 32'h8003,
                                 32'hFFFF_FFFC));
        send_transfer(make_issue(KIND_LDRH, 1, 0, 1, 0, 0, 1, 2, 15, 0, 32'h40, 32'd4));
        send_transfer(make_issue(KIND_STRH, 1, 0, 1, 1, 0, 1, 2, 15, 0, 32'h40, 32'd4));
        send_transfer(make_issue(KIND_LDRD, 1, 0, 1, 1, 0, 2, 5, 0, 0, 32'h100, 32'd4));
        send_transfer(make_issue(KIND_LDRSH, 1, 1, 1, 1, 1, 15, 15, 15, 3, '1, '1));
    endtask

    task automatic test_features_off();
        drain_results();
        write_config(REG_UNPRIV, 32'd0);
        write_config(REG_DUAL, 32'd0);
        write_config(REG_V6, 32'd0);
        write_config(REG_RESTORED, 32'd1);
        write_config(REG_ALIGN, 32'd1);
        write_config(REG_DMASK, 32'd0);
        send_transfer(make_issue(KIND_LDRH, 1, 0, 1, 1, 1, 1, 2, 0, 0, 32'h40, 32'd2));
        send_transfer(make_issue(KIND_LDRD, 1, 0, 1, 1, 0, 2, 5, 0, 0, 32'h100, 32'd8));
        send_transfer(make_issue(KIND_LDRH, 1, 1, 1, 0, 0, 1, 2, 2, 0, 32'h40, 32'd2));
        send_transfer(make_issue(KIND_LDRSH, 0, 0, 1, 1, 0, 1, 2, 0, 0, 32'h1001, 32'd2));
        send_transfer(make_issue(KIND_LDRSB, 1, 0, 1, 1, 0, 1, 2, 0, 0, 32'h3FF, 32'd0));
        send_transfer(make_issue(KIND_STRH, 1, 0, 0, 0, 0, 1, 2, 2, 1, 32'h43, 32'd1));
    endtask

    task automatic test_random_settings();
        int phase;
        int r;
        logic [31:0] value;
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            for (r = 0; r <= 5; r++) begin
                if (phase == 0)
                    value = 32'd0;
                else if (phase == 1)
                    value = (r == REG_DMASK) ? 32'd7 : 32'd1;
                else
                    value = (r == REG_DMASK) ? $urandom_range(7, 0) : $urandom_range(1, 0);
                write_config(3'(r), value);
            end
            gaps_on = (phase % 4) != 2;
            stalls_on = (phase % 4) != 2 && (phase % 4) != 3;
            repeat (ITEMS_PER_PHASE) send_transfer(random_issue());
        end
    endtask

    always begin : result_side_stall
        int n;
        @(negedge i_clk);
        n = stalls_on ? pick_gap() : 0;
        if (n == 0) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b1;
            repeat (n - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_stall === 1'b0)
            pending_issue_results.push_back(predict_issue_check(in_data));
    end

    always @(posedge i_clk) begin : result_check
        t_issue_out want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (pending_issue_results.size() == 0) begin
                report_mismatch("result transfer with no transfer pending");
            end else begin
                want = pending_issue_results.pop_front();
                check_field("undefined", 32'(o_out_data.undefined), 32'(want.undefined));
                check_field("access_address", o_out_data.access_address, want.access_address);
                check_field("second_address", o_out_data.second_address, want.second_address);
                check_field("access_size", 32'(o_out_data.access_size),
                            32'(want.access_size));
                check_field("store_op", 32'(o_out_data.store_op), 32'(want.store_op));
                check_field("sign_extend", 32'(o_out_data.sign_extend),
                            32'(want.sign_extend));
                check_field("alignment_fault", 32'(o_out_data.alignment_fault),
                            32'(want.alignment_fault));
                check_field("crosses_boundary", 32'(o_out_data.crosses_boundary),
                            32'(want.crosses_boundary));
                check_field("writeback_enable", 32'(o_out_data.writeback_enable),
                            32'(want.writeback_enable));
                check_field("writeback_value", o_out_data.writeback_value,
                            want.writeback_value);
                check_field("writeback_on_abort", 32'(o_out_data.writeback_on_abort),
                            32'(want.writeback_on_abort));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !out_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("arm_extra_load_store_issue_check_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_features_off();
        test_random_settings();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("arm_extra_load_store_issue_check_tb: PASS");
        else
            $display("arm_extra_load_store_issue_check_tb: FAIL");
        $finish;
    end
endmodule
